[hdl/assert_macros.svh]
// Assertion macros for the affine transform block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// expr must hold at every edge out of reset (uses clk and rst of the module)
`define AFF_ASSERT(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("affine block assertion failed");
// ante at one edge implies cons at the next
`define AFF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("affine block assertion failed");
`else
`define AFF_ASSERT(lbl, expr)
`define AFF_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[hdl/aff_pkg.sv]
// Shared types, register codes and arithmetic helpers for the affine transform
package aff_pkg;

  typedef enum logic [2:0] {
    REG_COEF_XX  = 3'd0,
    REG_COEF_XY  = 3'd1,
    REG_OFFSET_X = 3'd2,
    REG_COEF_YX  = 3'd3,
    REG_COEF_YY  = 3'd4,
    REG_OFFSET_Y = 3'd5
  } cfg_idx_t;

  localparam logic [31:0] COEF_ONE = 32'h0001_0000;
  localparam logic [30:0] SIZE_MAX = 31'h7FFF_FFFF;

  typedef struct packed {
    logic [31:0] xx;
    logic [31:0] xy;
    logic [31:0] ox;
    logic [31:0] yx;
    logic [31:0] yy;
    logic [31:0] oy;
  } coef_t;

  // corner coordinates: index 0 is left/top, 1 is right/bottom
  typedef struct packed {
    logic [31:0] x0;
    logic [31:0] y0;
    logic [31:0] x1;
    logic [31:0] y1;
    logic        ovf;
  } pts_t;

  // floored products, 48 bits signed each
  typedef struct packed {
    logic [47:0] xx0;
    logic [47:0] xx1;
    logic [47:0] xy0;
    logic [47:0] xy1;
    logic [47:0] yx0;
    logic [47:0] yx1;
    logic [47:0] yy0;
    logic [47:0] yy1;
    logic        ovf;
  } prod_t;

  typedef struct packed {
    logic [3:0][31:0] cx;
    logic [3:0][31:0] cy;
    logic             ovf;
  } corn_t;

  // floor(a*b / 2^16)
  function automatic logic [47:0] mul_q16(logic [31:0] a, logic [31:0] b);
    logic signed [63:0] p;
    p = 64'($signed(a)) * 64'($signed(b));
    return p[63:16];
  endfunction

  function automatic logic ovf32(logic [49:0] v);
    return (v[49:31] != {19{1'b0}}) && (v[49:31] != {19{1'b1}});
  endfunction

  function automatic logic [31:0] sat32(logic [49:0] v);
    if (!ovf32(v)) return v[31:0];
    else if (v[49]) return 32'h8000_0000;
    else return 32'h7FFF_FFFF;
  endfunction

  function automatic logic [31:0] smin(logic [31:0] a, logic [31:0] b);
    return ($signed(a) < $signed(b)) ? a : b;
  endfunction

  function automatic logic [31:0] smax(logic [31:0] a, logic [31:0] b);
    return ($signed(a) > $signed(b)) ? a : b;
  endfunction

endpackage

[hdl/affine_point_rect_transform.sv]
// Top level: configuration registers and the seven-stage transform pipeline
//
//  channel | signals                                      | dir
//  in      | in_valid in_ready kind left_x top_y          | request in
//          | rect_width rect_height                       |
//  out     | out_valid out_ready out_x out_y out_width    | request out
//          | out_height overflow                          |
//  cfg     | cfg_valid cfg_ready cfg_index cfg_data       | write in
//
// One request per cycle while the output is not stalled by out_ready.
// Stages: edge saturation, multipliers, pair sums, offset/saturate,
// two min/max levels, size. The eight 32x32 multipliers set the stage depth.
// Each stage holds its request while the next is full; ready ripples back.
// rst clears valid bits and loads the identity transform.
module affine_point_rect_transform (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        kind,
  input  logic [31:0] left_x,
  input  logic [31:0] top_y,
  input  logic [31:0] rect_width,
  input  logic [31:0] rect_height,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_x,
  output logic [31:0] out_y,
  output logic [30:0] out_width,
  output logic [30:0] out_height,
  output logic        overflow
);

  aff_pkg::coef_t coef;
  aff_pkg::pts_t  pts;
  aff_pkg::prod_t prod;
  aff_pkg::corn_t corn;
  logic           pts_valid;
  logic           pts_ready;
  logic           prod_valid;
  logic           prod_ready;
  logic           corn_valid;
  logic           corn_ready;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef.xx <= aff_pkg::COEF_ONE;
      coef.xy <= '0;
      coef.ox <= '0;
      coef.yx <= '0;
      coef.yy <= aff_pkg::COEF_ONE;
      coef.oy <= '0;
    end else if (cfg_valid) begin
      unique case (aff_pkg::cfg_idx_t'(cfg_index))
        aff_pkg::REG_COEF_XX:  coef.xx <= cfg_data;
        aff_pkg::REG_COEF_XY:  coef.xy <= cfg_data;
        aff_pkg::REG_OFFSET_X: coef.ox <= cfg_data;
        aff_pkg::REG_COEF_YX:  coef.yx <= cfg_data;
        aff_pkg::REG_COEF_YY:  coef.yy <= cfg_data;
        aff_pkg::REG_OFFSET_Y: coef.oy <= cfg_data;
        default: ;
      endcase
    end
  end

  aff_corner u_corner (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .kind        (kind),
    .left_x      (left_x),
    .top_y       (top_y),
    .rect_width  (rect_width),
    .rect_height (rect_height),
    .pts_valid   (pts_valid),
    .pts_ready   (pts_ready),
    .pts         (pts)
  );

  aff_mul u_mul (
    .clk        (clk),
    .rst        (rst),
    .coef       (coef),
    .pts_valid  (pts_valid),
    .pts_ready  (pts_ready),
    .pts        (pts),
    .prod_valid (prod_valid),
    .prod_ready (prod_ready),
    .prod       (prod)
  );

  aff_sum u_sum (
    .clk        (clk),
    .rst        (rst),
    .coef       (coef),
    .prod_valid (prod_valid),
    .prod_ready (prod_ready),
    .prod       (prod),
    .corn_valid (corn_valid),
    .corn_ready (corn_ready),
    .corn       (corn)
  );

  aff_box u_box (
    .clk        (clk),
    .rst        (rst),
    .corn_valid (corn_valid),
    .corn_ready (corn_ready),
    .corn       (corn),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_x      (out_x),
    .out_y      (out_y),
    .out_width  (out_width),
    .out_height (out_height),
    .overflow   (overflow)
  );

endmodule

[hdl/aff_corner.sv]
// Input stage: saturated right and bottom edges of a rectangle, or a point as both corners
module aff_corner (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic         kind,
  input  logic [31:0]  left_x,
  input  logic [31:0]  top_y,
  input  logic [31:0]  rect_width,
  input  logic [31:0]  rect_height,
  output logic         pts_valid,
  input  logic         pts_ready,
  output aff_pkg::pts_t pts
);

  logic [49:0]   sum_x;
  logic [49:0]   sum_y;
  aff_pkg::pts_t pts_next;

  assign in_ready = !pts_valid || pts_ready;

  always_comb begin
    sum_x = 50'($signed(left_x)) + 50'($signed(rect_width));
    sum_y = 50'($signed(top_y)) + 50'($signed(rect_height));
    pts_next.x0 = left_x;
    pts_next.y0 = top_y;
    // a point is a rectangle with both corners the same
    if (kind) begin
      pts_next.x1  = aff_pkg::sat32(sum_x);
      pts_next.y1  = aff_pkg::sat32(sum_y);
      pts_next.ovf = aff_pkg::ovf32(sum_x) || aff_pkg::ovf32(sum_y);
    end else begin
      pts_next.x1  = left_x;
      pts_next.y1  = top_y;
      pts_next.ovf = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pts_valid <= 1'b0;
    end else if (in_ready) begin
      pts_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      pts <= pts_next;
    end
  end

endmodule

[hdl/aff_mul.sv]
// Multiply stage: eight 32x32 products, floored to Q32.16
module aff_mul (
  input  logic           clk,
  input  logic           rst,
  input  aff_pkg::coef_t coef,
  input  logic           pts_valid,
  output logic           pts_ready,
  input  aff_pkg::pts_t  pts,
  output logic           prod_valid,
  input  logic           prod_ready,
  output aff_pkg::prod_t prod
);

  aff_pkg::prod_t prod_next;

  assign pts_ready = !prod_valid || prod_ready;

  always_comb begin
    prod_next.xx0 = aff_pkg::mul_q16(coef.xx, pts.x0);
    prod_next.xx1 = aff_pkg::mul_q16(coef.xx, pts.x1);
    prod_next.xy0 = aff_pkg::mul_q16(coef.xy, pts.y0);
    prod_next.xy1 = aff_pkg::mul_q16(coef.xy, pts.y1);
    prod_next.yx0 = aff_pkg::mul_q16(coef.yx, pts.x0);
    prod_next.yx1 = aff_pkg::mul_q16(coef.yx, pts.x1);
    prod_next.yy0 = aff_pkg::mul_q16(coef.yy, pts.y0);
    prod_next.yy1 = aff_pkg::mul_q16(coef.yy, pts.y1);
    prod_next.ovf = pts.ovf;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else if (pts_ready) begin
      prod_valid <= pts_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pts_ready && pts_valid) begin
      prod <= prod_next;
    end
  end

endmodule

[hdl/aff_sum.sv]
// Sum stages: product pairs per corner, then offset and saturation
module aff_sum (
  input  logic           clk,
  input  logic           rst,
  input  aff_pkg::coef_t coef,
  input  logic           prod_valid,
  output logic           prod_ready,
  input  aff_pkg::prod_t prod,
  output logic           corn_valid,
  input  logic           corn_ready,
  output aff_pkg::corn_t corn
);

  // corner i uses x index i[1] and y index i[0]
  logic [3:0][48:0] part_x;
  logic [3:0][48:0] part_y;
  logic [3:0][48:0] part_x_next;
  logic [3:0][48:0] part_y_next;
  logic             part_ovf;
  logic             part_valid;
  logic             part_ready;
  logic [3:0][49:0] tot_x;
  logic [3:0][49:0] tot_y;
  aff_pkg::corn_t   corn_next;

  assign prod_ready = !part_valid || part_ready;
  assign part_ready = !corn_valid || corn_ready;

  always_comb begin
    part_x_next[0] = 49'($signed(prod.xx0)) + 49'($signed(prod.xy0));
    part_x_next[1] = 49'($signed(prod.xx0)) + 49'($signed(prod.xy1));
    part_x_next[2] = 49'($signed(prod.xx1)) + 49'($signed(prod.xy0));
    part_x_next[3] = 49'($signed(prod.xx1)) + 49'($signed(prod.xy1));
    part_y_next[0] = 49'($signed(prod.yx0)) + 49'($signed(prod.yy0));
    part_y_next[1] = 49'($signed(prod.yx0)) + 49'($signed(prod.yy1));
    part_y_next[2] = 49'($signed(prod.yx1)) + 49'($signed(prod.yy0));
    part_y_next[3] = 49'($signed(prod.yx1)) + 49'($signed(prod.yy1));
  end

  always_comb begin
    corn_next.ovf = part_ovf;
    for (int i = 0; i < 4; i++) begin
      tot_x[i] = 50'($signed(part_x[i])) + 50'($signed(coef.ox));
      tot_y[i] = 50'($signed(part_y[i])) + 50'($signed(coef.oy));
      corn_next.cx[i] = aff_pkg::sat32(tot_x[i]);
      corn_next.cy[i] = aff_pkg::sat32(tot_y[i]);
      corn_next.ovf = corn_next.ovf || aff_pkg::ovf32(tot_x[i]) ||
                      aff_pkg::ovf32(tot_y[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      part_valid <= 1'b0;
      corn_valid <= 1'b0;
    end else begin
      if (prod_ready) begin
        part_valid <= prod_valid;
      end
      if (part_ready) begin
        corn_valid <= part_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (prod_ready && prod_valid) begin
      part_x   <= part_x_next;
      part_y   <= part_y_next;
      part_ovf <= prod.ovf;
    end
    if (part_ready && part_valid) begin
      corn <= corn_next;
    end
  end

endmodule

[hdl/aff_box.sv]
// Bounding box stages: min/max tree over four corners, then saturated size
`include "assert_macros.svh"

module aff_box (
  input  logic           clk,
  input  logic           rst,
  input  logic           corn_valid,
  output logic           corn_ready,
  input  aff_pkg::corn_t corn,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [31:0]    out_x,
  output logic [31:0]    out_y,
  output logic [30:0]    out_width,
  output logic [30:0]    out_height,
  output logic           overflow
);

  // first level: pairs {0,1} and {2,3}
  logic             pair_valid;
  logic             pair_ready;
  logic [1:0][31:0] pmin_x;
  logic [1:0][31:0] pmax_x;
  logic [1:0][31:0] pmin_y;
  logic [1:0][31:0] pmax_y;
  logic             pair_ovf;
  // second level
  logic             mm_valid;
  logic             mm_ready;
  logic [31:0]      min_x;
  logic [31:0]      max_x;
  logic [31:0]      min_y;
  logic [31:0]      max_y;
  logic             mm_ovf;
  logic [32:0]      diff_x;
  logic [32:0]      diff_y;
  logic             big_x;
  logic             big_y;

  assign corn_ready = !pair_valid || pair_ready;
  assign pair_ready = !mm_valid || mm_ready;
  assign mm_ready   = !out_valid || out_ready;

  always_comb begin
    diff_x = 33'($signed(max_x)) - 33'($signed(min_x));
    diff_y = 33'($signed(max_y)) - 33'($signed(min_y));
    big_x  = diff_x[32] || diff_x[31];
    big_y  = diff_y[32] || diff_y[31];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pair_valid <= 1'b0;
      mm_valid   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (corn_ready) begin
        pair_valid <= corn_valid;
      end
      if (pair_ready) begin
        mm_valid <= pair_valid;
      end
      if (mm_ready) begin
        out_valid <= mm_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (corn_ready && corn_valid) begin
      for (int i = 0; i < 2; i++) begin
        pmin_x[i] <= aff_pkg::smin(corn.cx[2*i], corn.cx[2*i+1]);
        pmax_x[i] <= aff_pkg::smax(corn.cx[2*i], corn.cx[2*i+1]);
        pmin_y[i] <= aff_pkg::smin(corn.cy[2*i], corn.cy[2*i+1]);
        pmax_y[i] <= aff_pkg::smax(corn.cy[2*i], corn.cy[2*i+1]);
      end
      pair_ovf <= corn.ovf;
    end
    if (pair_ready && pair_valid) begin
      min_x  <= aff_pkg::smin(pmin_x[0], pmin_x[1]);
      max_x  <= aff_pkg::smax(pmax_x[0], pmax_x[1]);
      min_y  <= aff_pkg::smin(pmin_y[0], pmin_y[1]);
      max_y  <= aff_pkg::smax(pmax_y[0], pmax_y[1]);
      mm_ovf <= pair_ovf;
    end
    if (mm_ready && mm_valid) begin
      out_x      <= min_x;
      out_y      <= min_y;
      out_width  <= big_x ? aff_pkg::SIZE_MAX : diff_x[30:0];
      out_height <= big_y ? aff_pkg::SIZE_MAX : diff_y[30:0];
      overflow   <= mm_ovf || big_x || big_y;
    end
  end

  `AFF_ASSERT(a_pair_order, !pair_valid || ($signed(pmin_x[0]) <= $signed(pmax_x[0]) && $signed(pmin_y[1]) <= $signed(pmax_y[1])))
  `AFF_ASSERT(a_box_order, !mm_valid || ($signed(min_x) <= $signed(max_x) && $signed(min_y) <= $signed(max_y)))
  `AFF_ASSERT_NEXT(a_mm_hold, mm_valid && !mm_ready, mm_valid && $stable(min_x) && $stable(max_y))
  `AFF_ASSERT_NEXT(a_size_ovf, mm_valid && mm_ready && (big_x || big_y), overflow)

endmodule
